// ----- rtl/aavr_pkg.sv -----
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types, constants and helpers for the axis-angle vector rotate unit.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned TdataInW    = 160;  // 3x32 + 4x16, already whole bytes
  localparam int unsigned TdataOutW   = 96;

  localparam logic signed [33:0] CordicGainInv = 34'sh026DD3B6A;
  localparam logic signed [33:0] OneQ30        = 34'sh040000000;

  typedef logic signed [33:0] cval_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               quad;
  } side_t;

  function automatic cval_t atan_tab(input logic [4:0] i);
    cval_t r;
    case (i)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA;
      5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30;
      5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C;
      5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3;
      5'd23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp to [-2^30, 2^30]
  function automatic logic signed [31:0] clamp_one(input cval_t v);
    logic signed [31:0] r;
    if (v > OneQ30) r = 32'sh40000000;
    else if (v < -OneQ30) r = -32'sh40000000;
    else r = v[31:0];
    return r;
  endfunction

  // floor((p + 2^29) / 2^30) of a 64-bit product
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t[63:30];
  endfunction

endpackage

// ----- rtl/axis_angle_vector_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_unit
// Rotates a Q16.16 vector about a Q2.14 unit axis by a binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one vector, axis and angle per transaction; m_axis returns
//   the rotated vector. Items are independent, one result per input.
//   Throughput: one transaction per cycle while s_axis_tready is high.
//   Path from input acceptance to m_axis_tvalid: 24 CORDIC stages (one
//   micro-rotation each), then quaternion, products, matrix and row products,
//   each one register stage, then row sum/saturate into the output register.
//   The whole pipe advances together; when m_axis_tready is low and the
//   output register is full, s_axis_tready drops and every stage holds, so
//   nothing is lost or repeated. A full output register does not stop the
//   pipe while it is being drained.
//   Reset clears all valid bits; the pipe is empty afterwards.
//   Results saturate to the signed 32-bit range.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [aavr_pkg::TdataInW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rot_x, rot_y, rot_z
  output logic [aavr_pkg::TdataOutW-1:0] m_axis_tdata
);
  import aavr_pkg::*;

  logic en;
  side_t side_in, c_side;
  logic c_vld;
  logic signed [31:0] c_sin, c_cos;

  logic out_vld_q;
  logic [TdataOutW-1:0] out_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    side_in.vx   = s_axis_tdata[31:0];
    side_in.vy   = s_axis_tdata[63:32];
    side_in.vz   = s_axis_tdata[95:64];
    side_in.ax   = s_axis_tdata[111:96];
    side_in.ay   = s_axis_tdata[127:112];
    side_in.az   = s_axis_tdata[143:128];
    side_in.quad = s_axis_tdata[159];
  end

  aavr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .angle_i (s_axis_tdata[158:144]),
    .side_i  (side_in),
    .valid_o (c_vld),
    .sin_o   (c_sin),
    .cos_o   (c_cos),
    .side_o  (c_side)
  );

  // stage A: quaternion
  logic a_vld_q;
  logic signed [33:0] qx_q, qy_q, qz_q, w_q;
  logic signed [31:0] avx_q, avy_q, avz_q;
  logic signed [47:0] px, py, pz;
  assign px = 48'(c_side.ax) * 48'(c_sin) + 48'sd8192;
  assign py = 48'(c_side.ay) * 48'(c_sin) + 48'sd8192;
  assign pz = 48'(c_side.az) * 48'(c_sin) + 48'sd8192;

  // stage B: ten products
  logic b_vld_q;
  logic signed [33:0] x2_q, y2_q, z2_q, w2_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [31:0] bvx_q, bvy_q, bvz_q;

  // stage C: matrix
  logic c2_vld_q;
  logic signed [33:0] m_q [9];
  logic signed [33:0] m_d [9];
  logic signed [31:0] cvx_q, cvy_q, cvz_q;

  function automatic logic signed [33:0] clamp2(input logic signed [35:0] v);
    logic signed [33:0] r;
    if (v > 36'sh080000000) r = 34'sh080000000;
    else if (v < -36'sh080000000) r = -34'sh080000000;
    else r = v[33:0];
    return r;
  endfunction

  always_comb begin
    m_d[0] = clamp2(36'(w2_q) + 36'(x2_q) - 36'(y2_q) - 36'(z2_q));
    m_d[1] = clamp2((36'(xy_q) - 36'(zw_q)) <<< 1);
    m_d[2] = clamp2((36'(xz_q) + 36'(yw_q)) <<< 1);
    m_d[3] = clamp2((36'(xy_q) + 36'(zw_q)) <<< 1);
    m_d[4] = clamp2(36'(w2_q) - 36'(x2_q) + 36'(y2_q) - 36'(z2_q));
    m_d[5] = clamp2((36'(yz_q) - 36'(xw_q)) <<< 1);
    m_d[6] = clamp2((36'(xz_q) - 36'(yw_q)) <<< 1);
    m_d[7] = clamp2((36'(yz_q) + 36'(xw_q)) <<< 1);
    m_d[8] = clamp2(36'(w2_q) - 36'(x2_q) - 36'(y2_q) + 36'(z2_q));
  end

  // stage D: nine row products
  logic d_vld_q;
  logic signed [33:0] t_q [9];

  // stage E: row sums, saturated
  logic signed [35:0] s0, s1, s2;
  assign s0 = 36'(t_q[0]) + 36'(t_q[1]) + 36'(t_q[2]);
  assign s1 = 36'(t_q[3]) + 36'(t_q[4]) + 36'(t_q[5]);
  assign s2 = 36'(t_q[6]) + 36'(t_q[7]) + 36'(t_q[8]);

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh07FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -36'sh080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c2_vld_q  <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= c_vld;
      b_vld_q   <= a_vld_q;
      c2_vld_q  <= b_vld_q;
      d_vld_q   <= c2_vld_q;
      out_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q  <= px[47:14];
      qy_q  <= py[47:14];
      qz_q  <= pz[47:14];
      w_q   <= 34'(c_cos);
      avx_q <= c_side.vx;
      avy_q <= c_side.vy;
      avz_q <= c_side.vz;

      x2_q  <= rnd30(64'(qx_q) * 64'(qx_q));
      y2_q  <= rnd30(64'(qy_q) * 64'(qy_q));
      z2_q  <= rnd30(64'(qz_q) * 64'(qz_q));
      w2_q  <= rnd30(64'(w_q) * 64'(w_q));
      xy_q  <= rnd30(64'(qx_q) * 64'(qy_q));
      xz_q  <= rnd30(64'(qx_q) * 64'(qz_q));
      yz_q  <= rnd30(64'(qy_q) * 64'(qz_q));
      xw_q  <= rnd30(64'(qx_q) * 64'(w_q));
      yw_q  <= rnd30(64'(qy_q) * 64'(w_q));
      zw_q  <= rnd30(64'(qz_q) * 64'(w_q));
      bvx_q <= avx_q;
      bvy_q <= avy_q;
      bvz_q <= avz_q;

      m_q   <= m_d;
      cvx_q <= bvx_q;
      cvy_q <= bvy_q;
      cvz_q <= bvz_q;

      t_q[0] <= rnd30(64'(m_q[0]) * 64'(cvx_q));
      t_q[1] <= rnd30(64'(m_q[1]) * 64'(cvy_q));
      t_q[2] <= rnd30(64'(m_q[2]) * 64'(cvz_q));
      t_q[3] <= rnd30(64'(m_q[3]) * 64'(cvx_q));
      t_q[4] <= rnd30(64'(m_q[4]) * 64'(cvy_q));
      t_q[5] <= rnd30(64'(m_q[5]) * 64'(cvz_q));
      t_q[6] <= rnd30(64'(m_q[6]) * 64'(cvx_q));
      t_q[7] <= rnd30(64'(m_q[7]) * 64'(cvy_q));
      t_q[8] <= rnd30(64'(m_q[8]) * 64'(cvz_q));

      out_q <= {sat32(s2), sat32(s1), sat32(s0)};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- rtl/aavr_cordic.sv -----
// ----------------------------------------------------------------------------
// aavr_cordic
// Pipelined 24-stage CORDIC, rotation mode: sine and cosine of the half angle.
// One stage per cycle, advance shared with the rest of the pipe.
// ----------------------------------------------------------------------------
module aavr_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [14:0]           angle_i,
  input  aavr_pkg::side_t       side_i,
  output logic                  valid_o,
  output logic signed [31:0]    sin_o,
  output logic signed [31:0]    cos_o,
  output aavr_pkg::side_t       side_o
);
  import aavr_pkg::*;

  cval_t x_q [CordicSteps+1];
  cval_t y_q [CordicSteps+1];
  cval_t z_q [CordicSteps+1];
  side_t side_q [CordicSteps+1];
  logic  vld_q [CordicSteps+1];

  always_comb begin
    x_q[0]    = CordicGainInv;
    y_q[0]    = '0;
    z_q[0]    = cval_t'({angle_i, 15'd0});
    side_q[0] = side_i;
    vld_q[0]  = valid_i;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    cval_t x_d, y_d, z_d;
    always_comb begin
      if (!z_q[i][33]) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - atan_tab(5'(i));
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + atan_tab(5'(i));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    valid_o = vld_q[CordicSteps];
    side_o  = side_q[CordicSteps];
    if (side_q[CordicSteps].quad) begin
      sin_o = clamp_one(x_q[CordicSteps]);
      cos_o = clamp_one(-y_q[CordicSteps]);
    end else begin
      sin_o = clamp_one(y_q[CordicSteps]);
      cos_o = clamp_one(x_q[CordicSteps]);
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the axis-angle vector rotate unit: drives vector, axis and
// angle transactions, predicts each rotated vector with a bit-exact model
// and compares every output transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import aavr_pkg::*;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic signed [15:0] ax, ay, az;
    logic [15:0]        ang;
  } rot_req_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz;
  } rot_vec_t;

  localparam int unsigned IdleLimit = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TdataInW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata;

  rot_vec_t rot_expected_q[$];
  int       n_mismatch = 0;
  int       idle_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  axis_angle_vector_rotate_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------- prediction ----------------
  localparam longint AtanTurn [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  function automatic longint lim(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // >>> on longint is an arithmetic (floor) shift
  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] row_sum(longint m0, longint m1, longint m2,
                                                 longint vx, longint vy, longint vz);
    longint s;
    s = qmul(m0, vx) + qmul(m1, vy) + qmul(m2, vz);
    s = lim(s, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    return s[31:0];
  endfunction

  function automatic rot_vec_t rotate_vector(rot_req_t r);
    longint x, y, z, dx, dy, sn, cs, qx, qy, qz;
    longint x2, y2, z2, w2, xy, xz, yz, xw, yw, zw;
    longint m [9];
    longint one, two;
    rot_vec_t o;
    one = 64'sd1 <<< 30;
    two = 64'sd1 <<< 31;
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'(r.ang[14:0]) <<< 15;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurn[i];
      end else begin
        x += dx; y -= dy; z += AtanTurn[i];
      end
    end
    if (r.ang[15]) begin
      sn = x; cs = -y;
    end else begin
      sn = y; cs = x;
    end
    sn = lim(sn, -one, one);
    cs = lim(cs, -one, one);
    qx = (longint'(r.ax) * sn + 8192) >>> 14;
    qy = (longint'(r.ay) * sn + 8192) >>> 14;
    qz = (longint'(r.az) * sn + 8192) >>> 14;
    x2 = qmul(qx, qx); y2 = qmul(qy, qy); z2 = qmul(qz, qz); w2 = qmul(cs, cs);
    xy = qmul(qx, qy); xz = qmul(qx, qz); yz = qmul(qy, qz);
    xw = qmul(qx, cs); yw = qmul(qy, cs); zw = qmul(qz, cs);
    m[0] = w2 + x2 - y2 - z2;
    m[1] = 2 * (xy - zw);
    m[2] = 2 * (xz + yw);
    m[3] = 2 * (xy + zw);
    m[4] = w2 - x2 + y2 - z2;
    m[5] = 2 * (yz - xw);
    m[6] = 2 * (xz - yw);
    m[7] = 2 * (yz + xw);
    m[8] = w2 - x2 - y2 + z2;
    for (int k = 0; k < 9; k++) m[k] = lim(m[k], -two, two);
    o.rx = row_sum(m[0], m[1], m[2], r.vx, r.vy, r.vz);
    o.ry = row_sum(m[3], m[4], m[5], r.vx, r.vy, r.vz);
    o.rz = row_sum(m[6], m[7], m[8], r.vx, r.vy, r.vz);
    return o;
  endfunction

  // ---------------- driving ----------------
  // tvalid stays high across back-to-back items; it drops only while idling
  task automatic send_rotation(rot_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {r.ang, r.az, r.ay, r.ax, r.vz, r.vy, r.vx};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rot_expected_q.push_back(rotate_vector(r));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("ERROR %s: got %h, expected %h at %0t", what, got, exp_v, $realtime);
    n_mismatch++;
  endtask

  always @(posedge clk_i) begin
    rot_vec_t e;
    if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rot_expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata[31:0], '0);
      end else begin
        e = rot_expected_q.pop_front();
        if (m_axis_tdata[31:0] !== e.rx) report_mismatch("rot_x", m_axis_tdata[31:0], e.rx);
        if (m_axis_tdata[63:32] !== e.ry) report_mismatch("rot_y", m_axis_tdata[63:32], e.ry);
        if (m_axis_tdata[95:64] !== e.rz) report_mismatch("rot_z", m_axis_tdata[95:64], e.rz);
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_vec();
    case ($urandom_range(7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    rot_req_t r;
    logic [15:0] angs [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                              16'h7FFF, 16'h8001, 16'hFFFF, 16'h2000};
    for (int i = 0; i < 8; i++) begin
      r = '{32'h00010000, 32'h00020000, 32'hFFFD0000, 16'sd0, 16'sd0, 16'sd16384, angs[i]};
      send_rotation(r);
    end
    r = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'sd16384, 16'sd16384,
          16'h4000};
    send_rotation(r);
    r = '{32'h80000000, 32'h80000000, 32'h80000000, -16'sd16384, 16'sd0, 16'sd0, 16'h8000};
    send_rotation(r);
    r = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h5555};
    send_rotation(r);
    r = '{32'hFFFFFFFF, 32'h1, 32'h12345678, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA};
    send_rotation(r);
    r = '{32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'h1234};
    send_rotation(r);
  endtask

  task automatic test_random(int n);
    rot_req_t r;
    for (int i = 0; i < n; i++) begin
      r.vx = pick_vec(); r.vy = pick_vec(); r.vz = pick_vec();
      r.ax = pick_axis(); r.ay = pick_axis(); r.az = pick_axis();
      r.ang = 16'($urandom);
      send_rotation(r);
    end
  endtask

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (rot_expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(320);
    send_idle_pct = 86; recv_stall_pct = 0;  test_random(300);
    send_idle_pct = 0;  recv_stall_pct = 86; test_random(300);
    send_idle_pct = 30; recv_stall_pct = 30; test_random(320);
    recv_stall_pct = 0;
    drain_pipe();
    if (n_mismatch == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
